[hdl/ipv4_header_accept_and_fragment_track_macros.svh]
// ---------------------------------------------------------------------------
// IPv4 header tracker assertion macros
// Clocked assertion wrappers, disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef IPV4_HEADER_ACCEPT_AND_FRAGMENT_TRACK_MACROS_SVH
`define IPV4_HEADER_ACCEPT_AND_FRAGMENT_TRACK_MACROS_SVH

// Property checked at every rising edge of clk_i outside reset.
`define IHAFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on the cycle after the antecedent.
`define IHAFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ipv4hft_pkg.sv]
// ---------------------------------------------------------------------------
// ipv4hft_pkg
// Types, constants and helpers shared by the IPv4 header tracker.
// ---------------------------------------------------------------------------
package ipv4hft_pkg;

  localparam int unsigned HeaderWords = 10;
  localparam int unsigned CountW      = 4;
  localparam int unsigned HeaderBytes = 20;

  localparam logic [3:0]  HeaderWordsC = 4'(HeaderWords);
  localparam logic [3:0]  LastWordC    = 4'(HeaderWords - 1);
  localparam logic [3:0]  DstHiWordC   = 4'(HeaderWords - 2);
  localparam logic [3:0]  TotLenWordC  = 4'd1;
  localparam logic [3:0]  IdentWordC   = 4'd2;
  localparam logic [3:0]  FlagsWordC   = 4'd3;
  localparam logic [3:0]  ProtoWordC   = 4'd4;

  localparam logic [15:0] CsumAllOnes  = 16'hffff;
  localparam logic [15:0] CsumZero     = 16'h0000;
  localparam int unsigned MoreFragBit  = 13;
  localparam logic [31:0] BcastAddr    = 32'hffff_ffff;
  localparam logic [15:0] SecondsMax   = 16'hffff;
  localparam logic [15:0] TimeoutReset = 16'd30;

  // Configuration register indexes
  localparam logic CfgLocalAddr = 1'b0;
  localparam logic CfgTimeout   = 1'b1;

  // Input action codes
  localparam logic ActWord = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_NOT_ADDRESSED = 3'd0,
    VERDICT_CSUM_BAD      = 3'd1,
    VERDICT_TIMEOUT       = 3'd2,
    VERDICT_FRAGMENT      = 3'd3,
    VERDICT_COMPLETE      = 3'd4,
    VERDICT_OUT_OF_SEQ    = 3'd5
  } verdict_e;

  typedef struct packed {
    logic        action;
    logic        start_req;
    logic [15:0] header_word;
  } in_item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] payload_length;
    logic [15:0] assembled_length;
    logic [15:0] packet_id;
    logic [7:0]  protocol;
  } out_item_t;

  // Ones'-complement add with end-around carry. The folded result never
  // exceeds 16 bits since the raw sum is at most 0x1fffe.
  function automatic logic [15:0] csum_fold(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, acc} + {1'b0, w};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

[hdl/ipv4hft_if.sv]
// ---------------------------------------------------------------------------
// ipv4hft channel interfaces
// Valid/ready channels for header words in and verdicts out.
// ---------------------------------------------------------------------------
interface ipv4hft_in_if;
  logic                  valid;
  logic                  ready;
  ipv4hft_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ipv4hft_out_if;
  logic                   valid;
  logic                   ready;
  ipv4hft_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/ipv4_header_accept_and_fragment_track.sv]
// ---------------------------------------------------------------------------
// ipv4_header_accept_and_fragment_track
// IPv4 header checksum/address check with fragment sequence tracking.
// ---------------------------------------------------------------------------
// Usage:
//   hdr_i carries one transfer per header word (action = word) or per
//   one-second tick (action = tick). start_req marks word 0 of a header.
//   After the tenth word of a header one verdict transfer leaves on res_o
//   with payload length, assembled length, identification and protocol.
//   Ticks, extra words and words 0..8 produce no output transfer.
//   Config writes (cfg_we_i/cfg_idx_i/cfg_data_i) are registered and are
//   only to be done while the block is idle.
// Timing:
//   The last word's transfer is held in the input register, where the verdict
//   is computed and loaded into the result register that drives res_o valid.
//   Throughput is one transfer per cycle; the input register stays open while
//   a finished verdict waits on res_o, so only a second verdict behind a
//   stalled one holds the pipe. Ticks and non-final words drain regardless.
// Reset:
//   Asynchronous, active low. Clears valids, word count, checksum, sequence
//   state and the timeout counter; timeout register returns to 30 seconds,
//   local address to zero. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "ipv4_header_accept_and_fragment_track_macros.svh"

module ipv4_header_accept_and_fragment_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  ipv4hft_in_if.sink          hdr_i,
  ipv4hft_out_if.source       res_o
);

  // Configuration registers
  logic [31:0] local_addr_q;
  logic [15:0] timeout_q;

  // Input register
  logic                  s1_valid_q;
  ipv4hft_pkg::in_item_t s1_item_q;

  // Header capture state
  logic [3:0]  word_cnt_q, word_cnt_d;
  logic [15:0] csum_q, csum_d;
  logic [15:0] dst_hi_q;      // upper half of destination (word 8)
  logic [15:0] ident_q;
  logic        more_frag_q;   // only the MF flag matters
  logic [15:0] tot_len_q;
  logic [7:0]  proto_q;

  // Sequence state
  logic [15:0] exp_ident_q, exp_ident_d;
  logic [15:0] run_len_q, run_len_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic        seen_q, seen_d;

  // Result register
  logic                   out_valid_q;
  ipv4hft_pkg::out_item_t out_item_q;

  // Stage-1 decode
  logic        is_tick;
  logic [3:0]  cnt_eff;
  logic        take_word;
  logic        last_word;
  logic        s1_fire;
  logic [15:0] csum_new;
  logic [31:0] dst_full;
  logic [15:0] payload;
  logic        addressed;
  logic        csum_ok;
  logic        late;
  logic [15:0] run_sum;
  ipv4hft_pkg::out_item_t res_d;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
      timeout_q    <= ipv4hft_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipv4hft_pkg::CfgLocalAddr: local_addr_q <= cfg_data_i;
        ipv4hft_pkg::CfgTimeout:   timeout_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register: refills whenever it is empty or drains this cycle
  // ---------------------------------------------------------------------
  assign hdr_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (hdr_i.ready) begin
      s1_valid_q <= hdr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_i.valid && hdr_i.ready) begin
      s1_item_q <= hdr_i.data;
    end
  end

  // ---------------------------------------------------------------------
  // Word processing
  // ---------------------------------------------------------------------
  assign is_tick   = (s1_item_q.action == ipv4hft_pkg::ActTick);
  // start flag restarts counting before the word is taken
  assign cnt_eff   = s1_item_q.start_req ? 4'd0 : word_cnt_q;
  assign take_word = !is_tick && (cnt_eff < ipv4hft_pkg::HeaderWordsC);
  assign last_word = take_word && (cnt_eff == ipv4hft_pkg::LastWordC);

  // Only a verdict needs room in the result register
  assign s1_fire = s1_valid_q && (!last_word || !out_valid_q || res_o.ready);

  assign csum_new = ipv4hft_pkg::csum_fold(s1_item_q.start_req ? 16'd0 : csum_q,
                                           s1_item_q.header_word);

  // On the last word the low half of the destination is the word itself
  assign dst_full  = {dst_hi_q, s1_item_q.header_word};
  assign payload   = (tot_len_q >= 16'(ipv4hft_pkg::HeaderBytes))
                     ? tot_len_q - 16'(ipv4hft_pkg::HeaderBytes) : 16'd0;
  assign addressed = (dst_full == local_addr_q) || (dst_full == ipv4hft_pkg::BcastAddr);
  assign csum_ok   = (csum_new == ipv4hft_pkg::CsumAllOnes) ||
                     (csum_new == ipv4hft_pkg::CsumZero);
  assign late      = seen_q && (elapsed_q >= timeout_q);
  assign run_sum   = run_len_q + payload;

  // Verdict and sequence update
  always_comb begin
    res_d.payload_length   = payload;
    res_d.packet_id        = ident_q;
    res_d.protocol         = proto_q;
    res_d.assembled_length = run_len_q;
    res_d.verdict          = ipv4hft_pkg::VERDICT_NOT_ADDRESSED;
    exp_ident_d            = exp_ident_q;
    run_len_d              = run_len_q;
    seen_d                 = seen_q;
    elapsed_d              = elapsed_q;

    if (is_tick) begin
      if (elapsed_q != ipv4hft_pkg::SecondsMax) begin
        elapsed_d = elapsed_q + 16'd1;
      end
    end else if (last_word) begin
      if (!addressed) begin
        res_d.verdict = ipv4hft_pkg::VERDICT_NOT_ADDRESSED;
      end else if (!csum_ok) begin
        res_d.verdict = ipv4hft_pkg::VERDICT_CSUM_BAD;
      end else begin
        seen_d    = 1'b1;
        elapsed_d = 16'd0;
        if (late) begin
          res_d.verdict = ipv4hft_pkg::VERDICT_TIMEOUT;
        end else if (ident_q == exp_ident_q) begin
          res_d.assembled_length = run_sum;
          if (more_frag_q) begin
            res_d.verdict = ipv4hft_pkg::VERDICT_FRAGMENT;
            run_len_d     = run_sum;
          end else begin
            res_d.verdict = ipv4hft_pkg::VERDICT_COMPLETE;
            run_len_d     = 16'd0;
            exp_ident_d   = exp_ident_q + 16'd1;
          end
        end else begin
          // same cleanup as a completed packet
          res_d.verdict          = ipv4hft_pkg::VERDICT_OUT_OF_SEQ;
          res_d.assembled_length = 16'd0;
          run_len_d              = 16'd0;
          exp_ident_d            = exp_ident_q + 16'd1;
        end
      end
    end
  end

  // Word counter and checksum: a start flag restarts both, and its word is always taken
  always_comb begin
    word_cnt_d = word_cnt_q;
    csum_d     = csum_q;
    if (!is_tick) begin
      if (s1_item_q.start_req) begin
        word_cnt_d = 4'd0;
        csum_d     = 16'd0;
      end
      if (take_word) begin
        word_cnt_d = cnt_eff + 4'd1;
        csum_d     = csum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_cnt_q  <= '0;
      csum_q      <= '0;
      dst_hi_q    <= '0;
      ident_q     <= '0;
      more_frag_q <= 1'b0;
      tot_len_q   <= '0;
      proto_q     <= '0;
      exp_ident_q <= '0;
      run_len_q   <= '0;
      elapsed_q   <= '0;
      seen_q      <= 1'b0;
    end else if (s1_fire) begin
      word_cnt_q  <= word_cnt_d;
      csum_q      <= csum_d;
      exp_ident_q <= exp_ident_d;
      run_len_q   <= run_len_d;
      elapsed_q   <= elapsed_d;
      seen_q      <= seen_d;
      if (take_word) begin
        case (cnt_eff)
          ipv4hft_pkg::TotLenWordC: tot_len_q   <= s1_item_q.header_word;
          ipv4hft_pkg::IdentWordC:  ident_q     <= s1_item_q.header_word;
          ipv4hft_pkg::FlagsWordC:  more_frag_q <=
                                      s1_item_q.header_word[ipv4hft_pkg::MoreFragBit];
          ipv4hft_pkg::ProtoWordC:  proto_q     <= s1_item_q.header_word[7:0];
          ipv4hft_pkg::DstHiWordC:  dst_hi_q    <= s1_item_q.header_word;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && last_word) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && last_word) begin
      out_item_q <= res_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_item_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `IHAFT_ASSERT(a_cnt_range, word_cnt_q <= ipv4hft_pkg::HeaderWordsC,
                "word count beyond header length")
  `IHAFT_ASSERT(a_no_overwrite, !(out_valid_q && !res_o.ready && s1_fire && last_word),
                "verdict loaded over a stalled verdict")
  `IHAFT_ASSERT_NEXT(a_seq_clear,
                     s1_fire && last_word &&
                     (res_d.verdict == ipv4hft_pkg::VERDICT_COMPLETE ||
                      res_d.verdict == ipv4hft_pkg::VERDICT_OUT_OF_SEQ),
                     run_len_q == 16'd0 && exp_ident_q == $past(exp_ident_q) + 16'd1,
                     "sequence state not reset after packet end")
  `IHAFT_ASSERT_NEXT(a_frag_len,
                     s1_fire && last_word && res_d.verdict == ipv4hft_pkg::VERDICT_FRAGMENT,
                     run_len_q == out_item_q.assembled_length && elapsed_q == 16'd0,
                     "fragment length not carried into running length")

endmodule
